// ----- sv/ffba_pkg.sv -----
// shared types and codes for the first-fit block allocator
// used by ffba_bitmap and first_fit_block_allocator_core; no dependencies
`default_nettype none

package ffba_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BM_OP_FIND,
        BM_OP_SET,
        BM_OP_CLEAR
    } bm_op_t;

    typedef enum logic [1:0] {
        BM_IDLE,
        BM_FIND,
        BM_WRITE
    } bm_state_t;

    typedef struct packed {
        logic   go;
        bm_op_t op;
    } bm_cmd_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic found;
    } bm_stat_t;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_FIND_GO,
        FS_FIND_WAIT,
        FS_SET_GO,
        FS_SET_WAIT,
        FS_SEARCH,
        FS_SHIFT,
        FS_UNSET_GO,
        FS_UNSET_WAIT,
        FS_CLR_GO,
        FS_CLR_WAIT,
        FS_RESP
    } ffba_state_t;

endpackage

`default_nettype wire

// ----- sv/first_fit_block_allocator_core.sv -----
// first-fit contiguous block allocator: request sequencer and allocation table
// depends on ffba_pkg and ffba_bitmap
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid, in_stall, opcode, owner_id,     | in
//          | request_size                              |
//  result  | out_valid, out_stall, status, first_block,| out
//          | last_block                                |
//
// allocate: the bitmap scans from block 0 up to the last block of the first free run, then
// marks the run as used; a failed scan answers once the whole map has been scanned
// free: the table is searched for the owner, later entries shift down, then the range is cleared
// clear: the whole bitmap is cleared; bad requests go straight to the result state after acceptance
// after reset the bitmap is swept clear before the first request is accepted
// the result register lets the next request start while a result is stalled
`default_nettype none

module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int BLOCKS  = 128,
    parameter int ENTRIES = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] owner_id,
    input  wire logic [7:0]  request_size,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [6:0]       first_block,
    output logic [6:0]       last_block
);

    localparam int BW  = $clog2(BLOCKS);
    localparam int SW  = $clog2(BLOCKS + 1);
    localparam int CW  = (SW > 8) ? SW : 8;
    localparam int EW  = $clog2(ENTRIES + 1);
    localparam int EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EDW = 16 + 2 * BW;

    ffba_state_t   state_reg, state_next;
    logic [15:0]   owner_reg, owner_next;
    logic [SW-1:0] size_reg, size_next;
    logic [EW-1:0] count_reg, count_next;
    logic [EW-1:0] eptr_reg, eptr_next;
    logic [BW-1:0] lo_reg, lo_next;
    logic [BW-1:0] hi_reg, hi_next;
    status_t       res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [BW-1:0] out_first_reg, out_first_next;
    logic [BW-1:0] out_last_reg, out_last_next;

    logic [EDW-1:0] entry_mem [ENTRIES];
    logic [EDW-1:0] ent_rd_reg;
    logic           ent_we;
    logic [EAW-1:0] ent_waddr;
    logic [EDW-1:0] ent_wdata;

    bm_cmd_t       bm_cmd;
    bm_stat_t      bm_stat;
    logic [BW-1:0] bm_lo;
    logic [BW-1:0] bm_hi;
    logic [BW-1:0] bm_first;
    logic [BW-1:0] bm_last;

    logic          accept;
    logic          size_bad;
    logic          table_full;
    logic          out_free;
    logic          owner_hit;
    logic [EW-1:0] eptr_inc;
    logic [EW-1:0] eptr_dec;
    logic [15:0]   ent_owner;
    logic [BW-1:0] ent_first;
    logic [BW-1:0] ent_last;
    logic [BW+6:0] first_wide;
    logic [BW+6:0] last_wide;

    ffba_bitmap #(
        .BLOCKS (BLOCKS)
    ) u_bitmap (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (bm_cmd),
        .size      (size_reg),
        .lo        (bm_lo),
        .hi        (bm_hi),
        .stat      (bm_stat),
        .run_first (bm_first),
        .run_last  (bm_last)
    );

    assign in_stall   = !((state_reg == FS_IDLE) && bm_stat.ready);
    assign accept     = in_valid && !in_stall;
    assign size_bad   = (request_size == 8'd0) || (CW'(request_size) > CW'(BLOCKS));
    assign table_full = (count_reg == EW'(ENTRIES));
    assign out_free   = !out_valid_reg || !out_stall;
    assign eptr_inc   = eptr_reg + 1'b1;
    assign eptr_dec   = eptr_reg - 1'b1;
    assign ent_owner  = ent_rd_reg[EDW-1 -: 16];
    assign ent_first  = ent_rd_reg[2*BW-1:BW];
    assign ent_last   = ent_rd_reg[BW-1:0];
    assign owner_hit  = (ent_owner == owner_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_ALLOC: state_next = (size_bad || table_full) ? FS_RESP : FS_FIND_GO;
                        OP_FREE:  state_next = (count_reg == '0) ? FS_RESP : FS_SEARCH;
                        OP_CLEAR: state_next = FS_CLR_GO;
                        default:  state_next = FS_RESP;
                    endcase
                end
            end
            FS_FIND_GO:   state_next = FS_FIND_WAIT;
            FS_FIND_WAIT:
            begin
                if (bm_stat.done)
                begin
                    state_next = bm_stat.found ? FS_SET_GO : FS_RESP;
                end
            end
            FS_SET_GO:    state_next = FS_SET_WAIT;
            FS_SET_WAIT:
            begin
                if (bm_stat.done)
                begin
                    state_next = FS_RESP;
                end
            end
            FS_SEARCH:
            begin
                if (owner_hit)
                begin
                    state_next = FS_SHIFT;
                end
                else if (eptr_inc == count_reg)
                begin
                    state_next = FS_RESP;
                end
            end
            FS_SHIFT:
            begin
                if (eptr_reg == count_reg)
                begin
                    state_next = FS_UNSET_GO;
                end
            end
            FS_UNSET_GO:  state_next = FS_UNSET_WAIT;
            FS_UNSET_WAIT:
            begin
                if (bm_stat.done)
                begin
                    state_next = FS_RESP;
                end
            end
            FS_CLR_GO:    state_next = FS_CLR_WAIT;
            FS_CLR_WAIT:
            begin
                if (bm_stat.done)
                begin
                    state_next = FS_RESP;
                end
            end
            FS_RESP:
            begin
                if (out_free)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:      state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        owner_next      = owner_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        eptr_next       = eptr_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        ent_we          = 1'b0;
        ent_waddr       = count_reg[EAW-1:0];
        ent_wdata       = {owner_reg, bm_first, bm_last};
        bm_cmd.go       = 1'b0;
        bm_cmd.op       = BM_OP_FIND;
        bm_lo           = lo_reg;
        bm_hi           = hi_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    owner_next = owner_id;
                    size_next  = SW'(request_size);
                    eptr_next  = '0;
                    lo_next    = '0;
                    hi_next    = '0;
                    case (opcode)
                        OP_ALLOC: res_status_next = ST_NO_SPACE;
                        OP_FREE:  res_status_next = ST_NOT_FOUND;
                        OP_CLEAR:
                        begin
                            res_status_next = ST_DONE;
                            count_next      = '0;
                        end
                        default:  res_status_next = ST_NOT_FOUND;
                    endcase
                end
            end
            FS_FIND_GO:
            begin
                bm_cmd.go = 1'b1;
                bm_cmd.op = BM_OP_FIND;
            end
            FS_FIND_WAIT:
            begin
                if (bm_stat.done && bm_stat.found)
                begin
                    lo_next         = bm_first;
                    hi_next         = bm_last;
                    ent_we          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_status_next = ST_DONE;
                end
            end
            FS_SET_GO:
            begin
                bm_cmd.go = 1'b1;
                bm_cmd.op = BM_OP_SET;
            end
            FS_SEARCH:
            begin
                if (owner_hit)
                begin
                    lo_next         = ent_first;
                    hi_next         = ent_last;
                    eptr_next       = eptr_inc;
                    res_status_next = ST_DONE;
                end
                else if (eptr_inc != count_reg)
                begin
                    eptr_next = eptr_inc;
                end
            end
            FS_SHIFT:
            begin
                // close the gap: entry eptr moves down by one
                if (eptr_reg == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    ent_we    = 1'b1;
                    ent_waddr = eptr_dec[EAW-1:0];
                    ent_wdata = ent_rd_reg;
                    eptr_next = eptr_inc;
                end
            end
            FS_UNSET_GO:
            begin
                bm_cmd.go = 1'b1;
                bm_cmd.op = BM_OP_CLEAR;
            end
            FS_CLR_GO:
            begin
                bm_cmd.go = 1'b1;
                bm_cmd.op = BM_OP_CLEAR;
                bm_lo     = '0;
                bm_hi     = BW'(BLOCKS - 1);
            end
            FS_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_first_next  = lo_reg;
                    out_last_next   = hi_reg;
                end
            end
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg      <= owner_next;
        size_reg       <= size_next;
        eptr_reg       <= eptr_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
    end

    // read address is eptr_next so ent_rd_reg matches eptr_reg
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= entry_mem[eptr_next[EAW-1:0]];
    end

    assign first_wide  = {7'd0, out_first_reg};
    assign last_wide   = {7'd0, out_last_reg};
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign first_block = first_wide[6:0];
    assign last_block  = last_wide[6:0];

    a_accept_bitmap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> bm_stat.ready)
        else $error("request taken while the bitmap was busy");

    a_go_bitmap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        bm_cmd.go |-> bm_stat.ready)
        else $error("bitmap command issued while it was busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= EW'(ENTRIES))
        else $error("allocation table count above its depth");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FS_SHIFT) |-> ((eptr_reg != '0) && (eptr_reg <= count_reg)))
        else $error("table compaction pointer out of range");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && (state_reg != FS_RESP)) |=> !out_valid_reg)
        else $error("result presented again after it was taken");

endmodule

`default_nettype wire

// ----- sv/ffba_bitmap.sv -----
// block usage bitmap: one-bit memory with a single walking pointer that either
// scans for the lowest free run or writes a range; depends on ffba_pkg
`default_nettype none

module ffba_bitmap
    import ffba_pkg::*;
#(
    parameter int BLOCKS = 128,
    localparam int BW = $clog2(BLOCKS),
    localparam int SW = $clog2(BLOCKS + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bm_cmd_t       cmd,
    input  wire logic [SW-1:0] size,
    input  wire logic [BW-1:0] lo,
    input  wire logic [BW-1:0] hi,
    output bm_stat_t           stat,
    output logic [BW-1:0]      run_first,
    output logic [BW-1:0]      run_last
);

    bm_state_t     state_reg, state_next;
    logic [BW-1:0] ptr_reg, ptr_next;
    logic [BW-1:0] hi_reg, hi_next;
    logic          wval_reg, wval_next;
    logic [SW-1:0] size_reg, size_next;
    logic [SW-1:0] run_reg, run_next;
    logic [BW-1:0] start_reg, start_next;
    logic          done_reg, done_next;
    logic          found_reg, found_next;
    logic [BW-1:0] first_reg, first_next;
    logic [BW-1:0] last_reg, last_next;
    logic          rd_reg;

    logic          used_mem [BLOCKS];

    logic [SW-1:0] run_inc;
    logic [BW-1:0] ptr_inc;
    logic          hit;
    logic          at_end;
    logic          wr_end;

    assign run_inc = run_reg + 1'b1;
    assign ptr_inc = ptr_reg + 1'b1;
    // rd_reg holds used_mem[ptr_reg] since the read address is ptr_next
    assign hit     = !rd_reg && (run_inc == size_reg);
    assign at_end  = (ptr_reg == BW'(BLOCKS - 1));
    assign wr_end  = (ptr_reg == hi_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BM_IDLE:
            begin
                if (cmd.go)
                begin
                    state_next = (cmd.op == BM_OP_FIND) ? BM_FIND : BM_WRITE;
                end
            end
            BM_FIND:
            begin
                if (hit || at_end)
                begin
                    state_next = BM_IDLE;
                end
            end
            BM_WRITE:
            begin
                if (wr_end)
                begin
                    state_next = BM_IDLE;
                end
            end
            default:
            begin
                state_next = BM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ptr_next   = ptr_reg;
        hi_next    = hi_reg;
        wval_next  = wval_reg;
        size_next  = size_reg;
        run_next   = run_reg;
        start_next = start_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        first_next = first_reg;
        last_next  = last_reg;
        case (state_reg)
            BM_IDLE:
            begin
                if (cmd.go)
                begin
                    ptr_next   = (cmd.op == BM_OP_FIND) ? '0 : lo;
                    hi_next    = hi;
                    wval_next  = (cmd.op == BM_OP_SET);
                    size_next  = size;
                    run_next   = '0;
                    start_next = '0;
                end
            end
            BM_FIND:
            begin
                ptr_next = ptr_inc;
                if (rd_reg)
                begin
                    run_next   = '0;
                    start_next = ptr_inc;
                end
                else
                begin
                    run_next = run_inc;
                end
                if (hit)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    first_next = start_reg;
                    last_next  = ptr_reg;
                end
                else if (at_end)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                end
            end
            BM_WRITE:
            begin
                ptr_next = ptr_inc;
                if (wr_end)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // after reset the pointer sweeps the whole map writing zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BM_WRITE;
            ptr_reg   <= '0;
            hi_reg    <= BW'(BLOCKS - 1);
            wval_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            hi_reg    <= hi_next;
            wval_reg  <= wval_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        run_reg   <= run_next;
        start_reg <= start_next;
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BM_WRITE)
        begin
            used_mem[ptr_reg] <= wval_reg;
        end
        rd_reg <= used_mem[ptr_next];
    end

    assign stat.ready = (state_reg == BM_IDLE);
    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign run_first  = first_reg;
    assign run_last   = last_reg;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BM_WRITE) |-> (ptr_reg <= hi_reg))
        else $error("bitmap write pointer passed the end of its range");

    a_run_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BM_FIND) |-> (run_reg < size_reg))
        else $error("free run grew past the requested size");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == BM_IDLE))
        else $error("bitmap signalled done while still busy");

    a_found_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (first_reg <= last_reg))
        else $error("found run ends before it starts");

endmodule

`default_nettype wire

// ----- bench/first_fit_block_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for first_fit_block_allocator_core: directed table, then random requests
// checks every result against a fixed expectation or an in-bench first-fit predictor; depends on ffba_pkg and the rtl

module first_fit_block_allocator_core_tb
    import ffba_pkg::*;
();

    localparam int BLOCKS         = 128;
    localparam int ENTRIES        = 128;
    localparam int DIRECTED_ROWS  = 25;
    localparam int TOTAL_ITEMS    = 1450;
    localparam int PHASE_ITEMS    = 480;
    localparam int TAIL_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        status_t    st;
        logic [6:0] first_blk;
        logic [6:0] last_blk;
    } alloc_result_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [15:0]   owner;
        logic [7:0]    size;
        bit            typed;
        alloc_result_t want;
    } dir_row_t;

    typedef struct {
        logic [15:0] owner;
        int          first_blk;
        int          last_blk;
    } table_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = 2'd0;
    logic [15:0] owner_id = 16'd0;
    logic [7:0]  request_size = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [6:0]  first_block;
    logic [6:0]  last_block;

    bit            block_busy [BLOCKS];
    table_entry_t  alloc_table [$];
    alloc_result_t outcomes_due [$];
    alloc_result_t due;
    dir_row_t      directed_rows [DIRECTED_ROWS];
    logic [15:0]   owner_pool [8];
    int            send_idle_pct = 9;
    int            recv_idle_pct = 72;
    int            items_sent = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    first_fit_block_allocator_core #(
        .BLOCKS  (BLOCKS),
        .ENTRIES (ENTRIES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .owner_id     (owner_id),
        .request_size (request_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .first_block  (first_block),
        .last_block   (last_block)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // first-fit outcome of one request, updating the bench's bitmap and table
    function automatic alloc_result_t allocator_outcome(input logic [1:0] op,
                                                        input logic [15:0] owner,
                                                        input logic [7:0] size);
        alloc_result_t res;
        table_entry_t  ent;
        int            i;
        int            j;
        int            run;
        int            start;
        int            idx;
        bit            hit;
        res.st = ST_NOT_FOUND;
        res.first_blk = 7'd0;
        res.last_blk = 7'd0;
        case (op)
            OP_ALLOC:
            begin
                res.st = ST_NO_SPACE;
                if (size != 8'd0 && size <= BLOCKS && alloc_table.size() < ENTRIES)
                begin
                    run = 0;
                    start = 0;
                    hit = 1'b0;
                    for (i = 0; i < BLOCKS && !hit; i++)
                    begin
                        if (block_busy[i])
                        begin
                            run = 0;
                            start = i + 1;
                        end
                        else
                        begin
                            run++;
                            if (run == size)
                            begin
                                hit = 1'b1;
                                for (j = start; j <= i; j++)
                                    block_busy[j] = 1'b1;
                                ent.owner = owner;
                                ent.first_blk = start;
                                ent.last_blk = i;
                                alloc_table.insert(alloc_table.size(), ent);
                                res.st = ST_DONE;
                                res.first_blk = 7'(start);
                                res.last_blk = 7'(i);
                            end
                        end
                    end
                end
            end
            OP_FREE:
            begin
                // earliest entry of this owner wins
                idx = -1;
                for (i = 0; i < alloc_table.size() && idx < 0; i++)
                    if (alloc_table[i].owner == owner)
                        idx = i;
                if (idx >= 0)
                begin
                    ent = alloc_table[idx];
                    for (j = ent.first_blk; j <= ent.last_blk; j++)
                        block_busy[j] = 1'b0;
                    alloc_table.delete(idx);
                    res.st = ST_DONE;
                    res.first_blk = 7'(ent.first_blk);
                    res.last_blk = 7'(ent.last_blk);
                end
            end
            OP_CLEAR:
            begin
                for (j = 0; j < BLOCKS; j++)
                    block_busy[j] = 1'b0;
                alloc_table.delete();
                res.st = ST_DONE;
            end
            default:
                res.st = ST_NOT_FOUND;
        endcase
        return res;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [15:0] owner,
                                input logic [7:0] size, input bit typed,
                                input alloc_result_t want);
        alloc_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        owner_id <= owner;
        request_size <= size;
        do
            @(posedge clk);
        while (in_stall);
        predicted = allocator_outcome(op, owner, size);
        outcomes_due.insert(outcomes_due.size(), typed ? want : predicted);
        items_sent++;
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result with no request outstanding: status %0d first %0d last %0d",
                       status, first_block, last_block);
                mismatch_count++;
            end
            else
            begin
                due = outcomes_due.pop_front();
                if (status !== due.st)
                begin
                    $error("status: expected %0d, got %0d", due.st, status);
                    mismatch_count++;
                end
                if (first_block !== due.first_blk)
                begin
                    $error("first_block: expected %0d, got %0d", due.first_blk, first_block);
                    mismatch_count++;
                end
                if (last_block !== due.last_blk)
                begin
                    $error("last_block: expected %0d, got %0d", due.last_blk, last_block);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("[first_fit_block_allocator_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          k;
        int          pick;
        int          phase;
        bit          table_filled;
        logic [1:0]  op;
        logic [15:0] who;
        logic [7:0]  amount;

        // empty allocator, bad sizes, unused opcode, full-width request
        directed_rows[0]  = '{OP_FREE,   16'h0005, 8'd0,   1'b1, '{ST_NOT_FOUND, 7'd0, 7'd0}};
        directed_rows[1]  = '{OP_ALLOC,  16'h0000, 8'd0,   1'b1, '{ST_NO_SPACE, 7'd0, 7'd0}};
        directed_rows[2]  = '{OP_ALLOC,  16'h0001, 8'd129, 1'b1, '{ST_NO_SPACE, 7'd0, 7'd0}};
        directed_rows[3]  = '{OP_ALLOC,  16'h0002, 8'd255, 1'b1, '{ST_NO_SPACE, 7'd0, 7'd0}};
        directed_rows[4]  = '{OP_UNUSED, 16'h0003, 8'd4,   1'b1, '{ST_NOT_FOUND, 7'd0, 7'd0}};
        directed_rows[5]  = '{OP_ALLOC,  16'hFFFF, 8'd128, 1'b1, '{ST_DONE, 7'd0, 7'd127}};
        directed_rows[6]  = '{OP_ALLOC,  16'h0001, 8'd1,   1'b1, '{ST_NO_SPACE, 7'd0, 7'd0}};
        directed_rows[7]  = '{OP_FREE,   16'hFFFF, 8'd0,   1'b1, '{ST_DONE, 7'd0, 7'd127}};
        // holes, duplicate owners and first-fit reuse, then clear, a near-full map, unused opcode and clear
        directed_rows[8]  = '{OP_ALLOC,  16'h0001, 8'd1,   1'b0, '0};
        directed_rows[9]  = '{OP_ALLOC,  16'h0002, 8'd3,   1'b0, '0};
        directed_rows[10] = '{OP_ALLOC,  16'h0001, 8'd5,   1'b0, '0};
        directed_rows[11] = '{OP_FREE,   16'h0001, 8'd0,   1'b0, '0};
        directed_rows[12] = '{OP_ALLOC,  16'h0003, 8'd1,   1'b0, '0};
        directed_rows[13] = '{OP_ALLOC,  16'h0004, 8'd2,   1'b0, '0};
        directed_rows[14] = '{OP_FREE,   16'h0002, 8'd0,   1'b0, '0};
        directed_rows[15] = '{OP_ALLOC,  16'h0005, 8'd2,   1'b0, '0};
        directed_rows[16] = '{OP_FREE,   16'h0001, 8'd0,   1'b0, '0};
        directed_rows[17] = '{OP_FREE,   16'h0001, 8'd0,   1'b1, '{ST_NOT_FOUND, 7'd0, 7'd0}};
        directed_rows[18] = '{OP_CLEAR,  16'h0000, 8'd0,   1'b1, '{ST_DONE, 7'd0, 7'd0}};
        directed_rows[19] = '{OP_ALLOC,  16'h8000, 8'd127, 1'b1, '{ST_DONE, 7'd0, 7'd126}};
        directed_rows[20] = '{OP_ALLOC,  16'h7FFF, 8'd2,   1'b0, '0};
        directed_rows[21] = '{OP_ALLOC,  16'h0001, 8'd1,   1'b0, '0};
        directed_rows[22] = '{OP_FREE,   16'h8000, 8'd0,   1'b0, '0};
        directed_rows[23] = '{OP_UNUSED, 16'hFFFF, 8'hFF,  1'b1, '{ST_NOT_FOUND, 7'd0, 7'd0}};
        directed_rows[24] = '{OP_CLEAR,  16'hFFFF, 8'hFF,  1'b1, '{ST_DONE, 7'd0, 7'd0}};

        owner_pool[0] = 16'h0000;
        owner_pool[1] = 16'hFFFF;
        for (k = 2; k < 8; k++)
            owner_pool[k] = 16'($urandom_range(0, 65535));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++)
            send_request(directed_rows[k].op, directed_rows[k].owner, directed_rows[k].size,
                         directed_rows[k].typed, directed_rows[k].want);

        phase = 0;
        table_filled = 1'b0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (phase < 2 && items_sent >= (phase + 1) * PHASE_ITEMS)
            begin
                // hold requests back until every result is home
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (outcomes_due.size() != 0);
                phase++;
                send_idle_pct = (phase == 1) ? 72 : 0;
                recv_idle_pct = (phase == 1) ? 9 : 0;
                table_filled = 1'b0;
            end
            if (!table_filled)
            begin
                // one block each until the table runs out, the last request is refused
                send_request(OP_CLEAR, 16'h0000, 8'd0, 1'b0, '0);
                for (k = 0; k <= ENTRIES; k++)
                    send_request(OP_ALLOC, owner_pool[k % 8], 8'd1, 1'b0, '0);
                table_filled = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    amount = 8'($urandom_range(1, 8));
                else if (pick < 90)
                    amount = 8'($urandom_range(9, 40));
                else if (pick < 96)
                    amount = 8'($urandom_range(41, 128));
                else if (pick < 98)
                    amount = 8'd0;
                else
                    amount = 8'($urandom_range(129, 255));
                if ($urandom_range(0, 99) < 70)
                    who = owner_pool[$urandom_range(0, 7)];
                else
                    who = 16'($urandom_range(0, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    op = OP_ALLOC;
                else if (pick < 92)
                begin
                    op = OP_FREE;
                    // mostly owners that really hold something
                    if (alloc_table.size() != 0 && $urandom_range(0, 99) < 65)
                        who = alloc_table[$urandom_range(0, alloc_table.size() - 1)].owner;
                end
                else if (pick < 95)
                    op = OP_CLEAR;
                else
                    op = OP_UNUSED;
                send_request(op, who, amount, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[first_fit_block_allocator_core] OK");
        else
            $display("[first_fit_block_allocator_core] ERROR");
        $finish;
    end

endmodule
